>>> rtl/rkpp_pkg.sv
`default_nettype none
package rkpp_pkg;

    // number format: signed fixed point
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_WIDTH  = 31;
    localparam int IDX_WIDTH  = 3;

    // register indexes
    localparam logic [IDX_WIDTH-1:0] REG_GROWTH_PREY     = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_PREDATION_RATE  = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_DEATH_PREDATOR  = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_CONVERSION_RATE = 3'd3;
    localparam logic [IDX_WIDTH-1:0] REG_STEP_SIZE       = 3'd4;

    // register reset values
    localparam logic [CFG_WIDTH-1:0] RST_GROWTH_PREY     = 31'd1966080;
    localparam logic [CFG_WIDTH-1:0] RST_PREDATION_RATE  = 31'd65536;
    localparam logic [CFG_WIDTH-1:0] RST_DEATH_PREDATOR  = 31'd1966080;
    localparam logic [CFG_WIDTH-1:0] RST_CONVERSION_RATE = 31'd65536;
    localparam logic [CFG_WIDTH-1:0] RST_STEP_SIZE       = 31'd655;

    // reciprocal of three for the averaging divide
    localparam logic [DATA_WIDTH:0] RECIP3 = 33'h055555556;

    localparam int DIV_LAT = 3;

    typedef logic signed [DATA_WIDTH-1:0]   word_t;
    typedef logic signed [2*DATA_WIDTH-1:0] prod_t;

    localparam word_t WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef struct packed {
        word_t val;
        logic  sat;
    } sat_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] a;
        logic [CFG_WIDTH-1:0] b;
        logic [CFG_WIDTH-1:0] c;
        logic [CFG_WIDTH-1:0] d;
        logic [CFG_WIDTH-1:0] h;
    } cfg_t;

    // per-item context carried alongside the arithmetic
    typedef struct packed {
        word_t t;
        word_t x;
        word_t y;
        word_t accp;
        word_t accq;
        logic  ovf;
    } ctx_t;

    typedef struct packed {
        word_t t;
        word_t x;
        word_t y;
        logic  ovf;
    } res_t;

    // product scaled back by FRAC_BITS, truncated toward zero, saturated
    function automatic sat_t mul_norm(input prod_t p);
        logic signed [2*DATA_WIDTH-FRAC_BITS-1:0] fl;
        logic signed [2*DATA_WIDTH-FRAC_BITS-1:0] r;
        logic                                     rnd;
        sat_t                                     o;
        fl    = p[2*DATA_WIDTH-1:FRAC_BITS];
        rnd   = p[2*DATA_WIDTH-1] && (|p[FRAC_BITS-1:0]);
        r     = fl + {{(2*DATA_WIDTH-FRAC_BITS-1){1'b0}}, rnd};
        o.sat = !((&r[2*DATA_WIDTH-FRAC_BITS-1:DATA_WIDTH-1])
                  || !(|r[2*DATA_WIDTH-FRAC_BITS-1:DATA_WIDTH-1]));
        if (o.sat) begin
            o.val = r[2*DATA_WIDTH-FRAC_BITS-1] ? WORD_MIN : WORD_MAX;
        end else begin
            o.val = r[DATA_WIDTH-1:0];
        end
        return o;
    endfunction

    function automatic sat_t sat_add(input word_t a, input word_t b);
        logic signed [DATA_WIDTH:0] s;
        sat_t                       o;
        s     = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
        o.sat = s[DATA_WIDTH] ^ s[DATA_WIDTH-1];
        o.val = o.sat ? (s[DATA_WIDTH] ? WORD_MIN : WORD_MAX) : s[DATA_WIDTH-1:0];
        return o;
    endfunction

    function automatic sat_t sat_sub(input word_t a, input word_t b);
        logic signed [DATA_WIDTH:0] s;
        sat_t                       o;
        s     = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
        o.sat = s[DATA_WIDTH] ^ s[DATA_WIDTH-1];
        o.val = o.sat ? (s[DATA_WIDTH] ? WORD_MIN : WORD_MAX) : s[DATA_WIDTH-1:0];
        return o;
    endfunction

    function automatic word_t cfg_word(input logic [CFG_WIDTH-1:0] v);
        return {{(DATA_WIDTH-CFG_WIDTH){1'b0}}, v};
    endfunction

endpackage
`default_nettype wire

>>> rtl/rkpp_delay.sv
`default_nettype none
module rkpp_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    output logic      [WIDTH-1:0] out_data
);
    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [DEPTH-1:0] valid_reg;

    // valid line, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[DEPTH-2:0], in_valid};
        end
    end

    // data line
    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg[0] <= in_data;
            for (int i = 1; i < DEPTH; i++) begin
                data_reg[i] <= data_reg[i-1];
            end
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign out_data  = data_reg[DEPTH-1];
endmodule
`default_nettype wire

>>> rtl/rkpp_slope.sv
`default_nettype none
// Lotka-Volterra slopes p = a*x - (b*x)*y, q = (d*x)*y - c*y, five stages
module rkpp_slope (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire rkpp_pkg::cfg_t cfg,
    input  wire rkpp_pkg::word_t x,
    input  wire rkpp_pkg::word_t y,
    output rkpp_pkg::word_t    p,
    output rkpp_pkg::word_t    q,
    output logic               ovf
);
    import rkpp_pkg::*;

    prod_t ax_p_reg, bx_p_reg, dx_p_reg, cy_p_reg;
    word_t y1_reg;
    word_t ax_reg, bx_reg, dx_reg, cy_reg, y2_reg;
    logic  f2_reg;
    prod_t bxy_p_reg, dxy_p_reg;
    word_t ax3_reg, cy3_reg;
    logic  f3_reg;
    word_t bxy_reg, dxy_reg, ax4_reg, cy4_reg;
    logic  f4_reg;
    word_t p_reg, q_reg;
    logic  f5_reg;

    sat_t ax_n, bx_n, dx_n, cy_n, bxy_n, dxy_n, p_n, q_n;

    assign ax_n  = mul_norm(ax_p_reg);
    assign bx_n  = mul_norm(bx_p_reg);
    assign dx_n  = mul_norm(dx_p_reg);
    assign cy_n  = mul_norm(cy_p_reg);
    assign bxy_n = mul_norm(bxy_p_reg);
    assign dxy_n = mul_norm(dxy_p_reg);
    assign p_n   = sat_sub(ax4_reg, bxy_reg);
    assign q_n   = sat_sub(dxy_reg, cy4_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            // first products
            ax_p_reg  <= cfg_word(cfg.a) * x;
            bx_p_reg  <= cfg_word(cfg.b) * x;
            dx_p_reg  <= cfg_word(cfg.d) * x;
            cy_p_reg  <= cfg_word(cfg.c) * y;
            y1_reg    <= y;
            // rescale
            ax_reg    <= ax_n.val;
            bx_reg    <= bx_n.val;
            dx_reg    <= dx_n.val;
            cy_reg    <= cy_n.val;
            y2_reg    <= y1_reg;
            f2_reg    <= ax_n.sat | bx_n.sat | dx_n.sat | cy_n.sat;
            // encounter products
            bxy_p_reg <= bx_reg * y2_reg;
            dxy_p_reg <= dx_reg * y2_reg;
            ax3_reg   <= ax_reg;
            cy3_reg   <= cy_reg;
            f3_reg    <= f2_reg;
            // rescale
            bxy_reg   <= bxy_n.val;
            dxy_reg   <= dxy_n.val;
            ax4_reg   <= ax3_reg;
            cy4_reg   <= cy3_reg;
            f4_reg    <= f3_reg | bxy_n.sat | dxy_n.sat;
            // differences
            p_reg     <= p_n.val;
            q_reg     <= q_n.val;
            f5_reg    <= f4_reg | p_n.sat | q_n.sat;
        end
    end

    assign p   = p_reg;
    assign q   = q_reg;
    assign ovf = f5_reg;
endmodule
`default_nettype wire

>>> rtl/rkpp_advance.sv
`default_nettype none
// x + step*p and y + step*q, three stages
module rkpp_advance (
    input  wire logic           aclk,
    input  wire logic           en,
    input  wire rkpp_pkg::word_t step,
    input  wire rkpp_pkg::word_t x,
    input  wire rkpp_pkg::word_t y,
    input  wire rkpp_pkg::word_t p,
    input  wire rkpp_pkg::word_t q,
    output rkpp_pkg::word_t     x_out,
    output rkpp_pkg::word_t     y_out,
    output logic                ovf
);
    import rkpp_pkg::*;

    prod_t hp_p_reg, hq_p_reg;
    word_t x1_reg, y1_reg;
    word_t hp_reg, hq_reg, x2_reg, y2_reg;
    logic  f2_reg;
    word_t xo_reg, yo_reg;
    logic  f3_reg;

    sat_t hp_n, hq_n, xs, ys;

    assign hp_n = mul_norm(hp_p_reg);
    assign hq_n = mul_norm(hq_p_reg);
    assign xs   = sat_add(x2_reg, hp_reg);
    assign ys   = sat_add(y2_reg, hq_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            hp_p_reg <= step * p;
            hq_p_reg <= step * q;
            x1_reg   <= x;
            y1_reg   <= y;
            hp_reg   <= hp_n.val;
            hq_reg   <= hq_n.val;
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            f2_reg   <= hp_n.sat | hq_n.sat;
            xo_reg   <= xs.val;
            yo_reg   <= ys.val;
            f3_reg   <= f2_reg | xs.sat | ys.sat;
        end
    end

    assign x_out = xo_reg;
    assign y_out = yo_reg;
    assign ovf   = f3_reg;
endmodule
`default_nettype wire

>>> rtl/rkpp_div6.sv
`default_nettype none
// two lanes of signed divide by six, truncating toward zero, three stages
module rkpp_div6 (
    input  wire logic           aclk,
    input  wire logic           en,
    input  wire rkpp_pkg::word_t a,
    input  wire rkpp_pkg::word_t b,
    output rkpp_pkg::word_t     a_q,
    output rkpp_pkg::word_t     b_q
);
    import rkpp_pkg::*;

    logic [DATA_WIDTH-1:0]   a_mag, b_mag;
    logic [DATA_WIDTH-2:0]   a_half_reg, b_half_reg;
    logic                    a_neg_reg, b_neg_reg, a_neg2_reg, b_neg2_reg;
    logic [2*DATA_WIDTH:0]   a_prod_reg, b_prod_reg;
    word_t                   a_tq, b_tq, a_q_reg, b_q_reg;

    assign a_mag = a[DATA_WIDTH-1] ? -a : a;
    assign b_mag = b[DATA_WIDTH-1] ? -b : b;
    // floor(n/3) = (n * RECIP3) >> DATA_WIDTH for n below 2^(DATA_WIDTH-1)
    assign a_tq  = a_prod_reg[2*DATA_WIDTH-1:DATA_WIDTH];
    assign b_tq  = b_prod_reg[2*DATA_WIDTH-1:DATA_WIDTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            a_half_reg <= a_mag[DATA_WIDTH-1:1];
            b_half_reg <= b_mag[DATA_WIDTH-1:1];
            a_neg_reg  <= a[DATA_WIDTH-1];
            b_neg_reg  <= b[DATA_WIDTH-1];
            a_prod_reg <= {{(DATA_WIDTH+2){1'b0}}, a_half_reg} * RECIP3;
            b_prod_reg <= {{(DATA_WIDTH+2){1'b0}}, b_half_reg} * RECIP3;
            a_neg2_reg <= a_neg_reg;
            b_neg2_reg <= b_neg_reg;
            a_q_reg    <= a_neg2_reg ? -a_tq : a_tq;
            b_q_reg    <= b_neg2_reg ? -b_tq : b_tq;
        end
    end

    assign a_q = a_q_reg;
    assign b_q = b_q_reg;
endmodule
`default_nettype wire

>>> rtl/rkpp_skid.sv
`default_nettype none
// two-entry result queue between the pipeline and the result channel
module rkpp_skid (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire rkpp_pkg::res_t in_data,
    output logic               has_room,
    output logic               m_valid,
    input  wire logic          m_ready,
    output rkpp_pkg::res_t     head
);
    import rkpp_pkg::*;

    logic [1:0] count_reg, count_next;
    res_t       head_reg, tail_reg;
    logic       pop;

    assign pop        = m_ready && (count_reg != 2'd0);
    assign count_next = count_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    // entry movement
    always_ff @(posedge aclk) begin
        if (pop) begin
            if (count_reg == 2'd2) begin
                head_reg <= tail_reg;
                if (push) begin
                    tail_reg <= in_data;
                end
            end else if (push) begin
                head_reg <= in_data;
            end
        end else if (push) begin
            if (count_reg == 2'd0) begin
                head_reg <= in_data;
            end else begin
                tail_reg <= in_data;
            end
        end
    end

    assign has_room = (count_reg != 2'd2) || m_ready;
    assign m_valid  = (count_reg != 2'd0);
    assign head     = head_reg;
endmodule
`default_nettype wire

>>> rtl/rk4_predator_prey_step.sv
`default_nettype none
// One classical fourth-order Runge-Kutta step of the Lotka-Volterra system in
// signed Q16.16, saturating; m_overflow flags any clamp along the way. The
// coefficients a, b, c, d and step h are to be written on the cfg port (index
// 0..4) only while the block is idle; the block itself does not enforce this.
// Throughput is one transaction per cycle while the result queue has room;
// the path to it is four slope evaluations (five stages each), four
// multiply-and-add updates (three each) and the divide by six (three). A
// two-entry result queue lets the pipeline keep taking input while a result
// waits; when it is full and m_ready is low, the whole pipeline holds.
module rk4_predator_prey_step (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [31:0]                 s_time_now,
    input  wire logic signed [31:0]                 s_prey_now,
    input  wire logic signed [31:0]                 s_predator_now,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [31:0]                      m_time_next,
    output logic signed [31:0]                      m_prey_next,
    output logic signed [31:0]                      m_predator_next,
    output logic                                    m_overflow,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [rkpp_pkg::IDX_WIDTH-1:0]     cfg_index,
    input  wire logic [rkpp_pkg::CFG_WIDTH-1:0]     cfg_data
);
    import rkpp_pkg::*;

    localparam int SLOPE_LAT = 5;
    localparam int ADV_LAT   = 3;
    localparam int CTX_W     = $bits(ctx_t);

    cfg_t  cfg_reg;
    logic  en;
    word_t h_w, hh_w;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.a <= RST_GROWTH_PREY;
            cfg_reg.b <= RST_PREDATION_RATE;
            cfg_reg.c <= RST_DEATH_PREDATOR;
            cfg_reg.d <= RST_CONVERSION_RATE;
            cfg_reg.h <= RST_STEP_SIZE;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_GROWTH_PREY:     cfg_reg.a <= cfg_data;
                REG_PREDATION_RATE:  cfg_reg.b <= cfg_data;
                REG_DEATH_PREDATOR:  cfg_reg.c <= cfg_data;
                REG_CONVERSION_RATE: cfg_reg.d <= cfg_data;
                REG_STEP_SIZE:       cfg_reg.h <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign h_w       = cfg_word(cfg_reg.h);
    assign hh_w      = cfg_word({1'b0, cfg_reg.h[CFG_WIDTH-1:1]});

    // fold a slope pair into the running weighted sums
    function automatic ctx_t fold(input ctx_t c, input word_t p, input word_t q,
                                  input logic dbl, input logic f);
        sat_t pd, qd, ps, qs;
        ctx_t o;
        if (dbl) begin
            pd = sat_add(p, p);
            qd = sat_add(q, q);
        end else begin
            pd.val = p;
            pd.sat = 1'b0;
            qd.val = q;
            qd.sat = 1'b0;
        end
        ps     = sat_add(c.accp, pd.val);
        qs     = sat_add(c.accq, qd.val);
        o      = c;
        o.accp = ps.val;
        o.accq = qs.val;
        o.ovf  = c.ovf | f | pd.sat | qd.sat | ps.sat | qs.sat;
        return o;
    endfunction

    ctx_t  c0, c0d, c1, c1d, c1e, c2d, c2, c2e, c2f, c3d, c3, c3e, c3f, c4d, c4, c5, c6;
    logic  v1, v2, v3, v4, v5, v6, v7, v8, v9;
    word_t p1, q1, p2, q2, p3, q3, p4, q4, xa, ya, xb, yb, xc, yc, sp, sq, xn, yn;
    logic  f1, f2, f3, f4, fa, fb, fc, fn;
    sat_t  tn;
    res_t  res;
    logic  room;

    assign en      = room;
    assign s_ready = en;

    assign c0 = '{t: s_time_now, x: s_prey_now, y: s_predator_now,
                  accp: '0, accq: '0, ovf: 1'b0};

    // first slope at (x, y)
    rkpp_slope u_slope1 (.aclk, .en, .cfg(cfg_reg), .x(c0.x), .y(c0.y),
                         .p(p1), .q(q1), .ovf(f1));
    rkpp_delay #(.WIDTH(CTX_W), .DEPTH(SLOPE_LAT)) u_dly1 (
        .aclk, .aresetn, .en, .in_valid(s_valid && en), .in_data(c0),
        .out_valid(v1), .out_data(c0d));
    assign c1 = fold(c0d, p1, q1, 1'b0, f1);

    // half step along slope one
    rkpp_advance u_adv1 (.aclk, .en, .step(hh_w), .x(c1.x), .y(c1.y), .p(p1), .q(q1),
                         .x_out(xa), .y_out(ya), .ovf(fa));
    rkpp_delay #(.WIDTH(CTX_W), .DEPTH(ADV_LAT)) u_dly2 (
        .aclk, .aresetn, .en, .in_valid(v1), .in_data(c1),
        .out_valid(v2), .out_data(c1d));
    always_comb begin
        c1e     = c1d;
        c1e.ovf = c1d.ovf | fa;
    end

    // second slope
    rkpp_slope u_slope2 (.aclk, .en, .cfg(cfg_reg), .x(xa), .y(ya),
                         .p(p2), .q(q2), .ovf(f2));
    rkpp_delay #(.WIDTH(CTX_W), .DEPTH(SLOPE_LAT)) u_dly3 (
        .aclk, .aresetn, .en, .in_valid(v2), .in_data(c1e),
        .out_valid(v3), .out_data(c2d));
    assign c2 = fold(c2d, p2, q2, 1'b1, f2);

    // half step along slope two
    rkpp_advance u_adv2 (.aclk, .en, .step(hh_w), .x(c2.x), .y(c2.y), .p(p2), .q(q2),
                         .x_out(xb), .y_out(yb), .ovf(fb));
    rkpp_delay #(.WIDTH(CTX_W), .DEPTH(ADV_LAT)) u_dly4 (
        .aclk, .aresetn, .en, .in_valid(v3), .in_data(c2),
        .out_valid(v4), .out_data(c2e));
    always_comb begin
        c2f     = c2e;
        c2f.ovf = c2e.ovf | fb;
    end

    // third slope
    rkpp_slope u_slope3 (.aclk, .en, .cfg(cfg_reg), .x(xb), .y(yb),
                         .p(p3), .q(q3), .ovf(f3));
    rkpp_delay #(.WIDTH(CTX_W), .DEPTH(SLOPE_LAT)) u_dly5 (
        .aclk, .aresetn, .en, .in_valid(v4), .in_data(c2f),
        .out_valid(v5), .out_data(c3d));
    assign c3 = fold(c3d, p3, q3, 1'b1, f3);

    // full step along slope three
    rkpp_advance u_adv3 (.aclk, .en, .step(h_w), .x(c3.x), .y(c3.y), .p(p3), .q(q3),
                         .x_out(xc), .y_out(yc), .ovf(fc));
    rkpp_delay #(.WIDTH(CTX_W), .DEPTH(ADV_LAT)) u_dly6 (
        .aclk, .aresetn, .en, .in_valid(v5), .in_data(c3),
        .out_valid(v6), .out_data(c3e));
    always_comb begin
        c3f     = c3e;
        c3f.ovf = c3e.ovf | fc;
    end

    // fourth slope
    rkpp_slope u_slope4 (.aclk, .en, .cfg(cfg_reg), .x(xc), .y(yc),
                         .p(p4), .q(q4), .ovf(f4));
    rkpp_delay #(.WIDTH(CTX_W), .DEPTH(SLOPE_LAT)) u_dly7 (
        .aclk, .aresetn, .en, .in_valid(v6), .in_data(c3f),
        .out_valid(v7), .out_data(c4d));
    assign c4 = fold(c4d, p4, q4, 1'b0, f4);

    // weighted sums over six
    rkpp_div6 u_div6 (.aclk, .en, .a(c4.accp), .b(c4.accq), .a_q(sp), .b_q(sq));
    rkpp_delay #(.WIDTH(CTX_W), .DEPTH(DIV_LAT)) u_dly8 (
        .aclk, .aresetn, .en, .in_valid(v7), .in_data(c4),
        .out_valid(v8), .out_data(c5));

    // final update
    rkpp_advance u_adv4 (.aclk, .en, .step(h_w), .x(c5.x), .y(c5.y), .p(sp), .q(sq),
                         .x_out(xn), .y_out(yn), .ovf(fn));
    rkpp_delay #(.WIDTH(CTX_W), .DEPTH(ADV_LAT)) u_dly9 (
        .aclk, .aresetn, .en, .in_valid(v8), .in_data(c5),
        .out_valid(v9), .out_data(c6));

    assign tn  = sat_add(c6.t, h_w);
    assign res = '{t: tn.val, x: xn, y: yn, ovf: c6.ovf | fn | tn.sat};

    // result queue
    res_t head;
    rkpp_skid u_skid (.aclk, .aresetn, .push(v9 && en), .in_data(res), .has_room(room),
                      .m_valid, .m_ready, .head);

    assign m_time_next     = head.t;
    assign m_prey_next     = head.x;
    assign m_predator_next = head.y;
    assign m_overflow      = head.ovf;
endmodule
`default_nettype wire

>>> rtl/rkpp_checker.sv
`default_nettype none
module rkpp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [31:0] s_time_now,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_time_next,
    input wire logic [31:0] m_prey_next,
    input wire logic [31:0] m_predator_next,
    input wire logic        m_overflow
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_time_next) && $stable(m_prey_next)
            && $stable(m_predator_next) && $stable(m_overflow))
        else $error("result changed while stalled");

    // a waiting input holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_time_now))
        else $error("input changed while waiting");

    // reset empties the block and opens the input
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("state after reset wrong");

    // input only held back by a full, stalled result queue
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output back-pressure");
endmodule

bind rk4_predator_prey_step rkpp_checker u_rkpp_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .s_time_now, .m_valid, .m_ready,
    .m_time_next, .m_prey_next, .m_predator_next, .m_overflow
);
`default_nettype wire
